[rtl/ppm_pulse_channel_decoder_top_assert.svh]
// Assertion macros for the PPM pulse channel decoder.
// Included by the top level; needs a clock and an active-high reset in scope.
`ifndef PPM_PULSE_CHANNEL_DECODER_TOP_ASSERT_SVH
`define PPM_PULSE_CHANNEL_DECODER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPMD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppm decoder assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PPMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppm decoder assertion failed");

`endif

[rtl/ppmd_pkg.sv]
// Shared constants, types and helpers of the PPM pulse channel decoder.
// Used by the serial divider and the top level; depends on nothing else.
`default_nettype none

package ppmd_pkg;

   localparam int MAX_CHANNELS = 12;
   localparam int WIDTH_BITS   = 16;
   localparam int IDX_BITS     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_BITS     = $clog2(MAX_CHANNELS + 1);
   localparam int CHAN_BITS    = 4;
   localparam int FRAC_BITS    = 10;
   localparam int STEP_BITS    = $clog2(FRAC_BITS + 1);
   localparam int CSR_ADDR_BITS = 2;

   localparam logic [WIDTH_BITS-1:0] RUNT_LIMIT   = WIDTH_BITS'(5);
   localparam logic [WIDTH_BITS-1:0] JITTER_LIMIT = WIDTH_BITS'(2);
   localparam logic [FRAC_BITS:0]    FULL_SCALE   = (FRAC_BITS + 1)'(1024);
   localparam logic [FRAC_BITS-1:0]  POS_MAX      = FRAC_BITS'(1023);
   localparam logic [FRAC_BITS-1:0]  SLEW_STEP    = FRAC_BITS'(100);

   localparam logic [CSR_ADDR_BITS-1:0] CSR_SEPARATOR = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SYNC      = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MIN       = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MAX       = 2'd3;

   localparam logic [WIDTH_BITS-1:0] SEPARATOR_RESET = WIDTH_BITS'(100);
   localparam logic [WIDTH_BITS-1:0] SYNC_RESET      = WIDTH_BITS'(870);
   localparam logic [WIDTH_BITS-1:0] MIN_RESET       = WIDTH_BITS'(130);
   localparam logic [WIDTH_BITS-1:0] MAX_RESET       = WIDTH_BITS'(330);

   typedef struct packed {
      logic                 done;
      logic                 exact;
      logic [FRAC_BITS-1:0] quot;
   } div_res_type;

   // Futaba order rotates the first three channels (0 to 1, 1 to 2, 2 to 0); JR keeps them.
   function automatic logic [CHAN_BITS-1:0] map_channel(input logic [IDX_BITS-1:0] idx,
                                                        input logic jr);
      logic [CHAN_BITS-1:0] chan;
      chan = CHAN_BITS'(idx);
      if (!jr) begin
         if (idx == IDX_BITS'(0)) begin
            chan = CHAN_BITS'(1);
         end else if (idx == IDX_BITS'(1)) begin
            chan = CHAN_BITS'(2);
         end else if (idx == IDX_BITS'(2)) begin
            chan = CHAN_BITS'(0);
         end
      end
      return chan;
   endfunction

endpackage

`default_nettype wire

[rtl/ppmd_divider.sv]
// Restoring serial divider giving the fractional quotient (a << 10) / span for a < span.
// One compare and subtract per cycle; depends on ppmd_pkg.
`default_nettype none

module ppmd_divider (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [ppmd_pkg::WIDTH_BITS-1:0] dividend,
   input  wire logic [ppmd_pkg::WIDTH_BITS-1:0] divisor,
   output ppmd_pkg::div_res_type               result
);
   import ppmd_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_BITS-1:0]  cnt_ff, cnt_in;
   logic [WIDTH_BITS-1:0] rem_ff, rem_in;
   logic [WIDTH_BITS-1:0] div_ff, div_in;
   logic [FRAC_BITS-1:0]  quot_ff, quot_in;
   logic [WIDTH_BITS:0]   shifted;
   logic                  fits;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      fits    = shifted >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = STEP_BITS'(FRAC_BITS);
         rem_in  = dividend;
         div_in  = divisor;
         quot_in = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = WIDTH_BITS'(shifted - {1'b0, div_ff});
         end else begin
            rem_in = shifted[WIDTH_BITS-1:0];
         end
         quot_in = {quot_ff[FRAC_BITS-2:0], fits};
         cnt_in  = cnt_ff - STEP_BITS'(1);
         if (cnt_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      quot_ff <= quot_in;
   end

   assign result.done  = done_ff;
   assign result.exact = (rem_ff == '0);
   assign result.quot  = quot_ff;

endmodule

`default_nettype wire

[rtl/ppm_pulse_channel_decoder_top.sv]
// Top level of the PPM pulse channel decoder: handshakes, sequencer and channel stores.
// Depends on ppmd_pkg, ppmd_divider and the assertion macro header.
`default_nettype none
`include "ppm_pulse_channel_decoder_top_assert.svh"

// Takes one measured pulse width per transfer and returns at most one result per pulse.
// Runts, separators, the pulse after a sync and pulses outside a synced frame finish in the
// idle state; a sync pulse goes from idle straight to the done state. A channel pulse passes
// through the check, divide, smooth and done states, waiting in divide on the serial divider
// that scales the width one quotient bit per cycle; a width at or beyond either end of the
// scale, or an empty scale range, skips the divider. The result sits in an output register,
// so a finished result waits there while the next pulse is taken in; a second finished result
// holds the block, with its input stalled, until the first is taken. The channel stores are
// cleared by reset and need no clearing pass.
module ppm_pulse_channel_decoder_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_ready,
   input  wire logic [ppmd_pkg::WIDTH_BITS-1:0]    req_pulse_width,
   input  wire logic                               req_inverted_polarity,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   output      logic                               rsp_frame_end,
   output      logic [ppmd_pkg::CHAN_BITS-1:0]     rsp_channel,
   output      logic [ppmd_pkg::FRAC_BITS-1:0]     rsp_position,
   output      logic [ppmd_pkg::CHAN_BITS-1:0]     rsp_channel_count,
   input  wire logic                               csr_we,
   input  wire logic [ppmd_pkg::CSR_ADDR_BITS-1:0] csr_index,
   input  wire logic [ppmd_pkg::WIDTH_BITS-1:0]    csr_wdata
);
   import ppmd_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_SMOOTH = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic                  synced_ff, synced_in;
   logic                  skip_ff, skip_in;
   logic [CNT_BITS-1:0]   idx_ff, idx_in;
   logic [WIDTH_BITS-1:0] sep_ff, sync_ff, min_ff, max_ff;
   logic [WIDTH_BITS-1:0] prev_ff [MAX_CHANNELS];
   logic [FRAC_BITS-1:0]  smooth_ff [MAX_CHANNELS];
   logic [WIDTH_BITS-1:0] width_ff, width_in;
   logic                  jr_ff, jr_in;
   logic [FRAC_BITS-1:0]  raw_ff, raw_in;
   logic                  res_frame_ff, res_frame_in;
   logic [CHAN_BITS-1:0]  res_chan_ff, res_chan_in;
   logic [FRAC_BITS-1:0]  res_pos_ff, res_pos_in;
   logic [CHAN_BITS-1:0]  res_count_ff, res_count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_frame_ff;
   logic [CHAN_BITS-1:0]  rsp_chan_ff, rsp_count_ff;
   logic [FRAC_BITS-1:0]  rsp_pos_ff;

   logic [IDX_BITS-1:0]   idx;
   logic [WIDTH_BITS-1:0] prev_w, w_snap, span, offset;
   logic                  prev_we, smooth_we, div_start, rsp_load;
   logic [FRAC_BITS-1:0]  s_old, s_new;
   logic [FRAC_BITS:0]    jr_val, avg_sum;
   div_res_type           div_res;

   assign idx    = idx_ff[IDX_BITS-1:0];
   assign prev_w = prev_ff[idx];
   assign s_old  = smooth_ff[idx];
   assign span   = max_ff - min_ff;
   assign offset = w_snap - min_ff;

   ppmd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (offset),
      .divisor  (span),
      .result   (div_res)
   );

   always_comb begin
      if (((prev_w > width_ff) ? (prev_w - width_ff) : (width_ff - prev_w)) < JITTER_LIMIT) begin
         w_snap = prev_w;
      end else begin
         w_snap = width_ff;
      end
      jr_val  = FULL_SCALE - {1'b0, div_res.quot} - (FRAC_BITS + 1)'(!div_res.exact);
      avg_sum = {1'b0, s_old} + {1'b0, raw_ff};
      if (s_old > raw_ff && (s_old - raw_ff) > SLEW_STEP) begin
         s_new = s_old - SLEW_STEP;
      end else if (raw_ff > s_old && (raw_ff - s_old) > SLEW_STEP) begin
         s_new = s_old + SLEW_STEP;
      end else begin
         s_new = avg_sum[FRAC_BITS:1];
      end
   end

   always_comb begin
      state_in     = state_ff;
      synced_in    = synced_ff;
      skip_in      = skip_ff;
      idx_in       = idx_ff;
      width_in     = width_ff;
      jr_in        = jr_ff;
      raw_in       = raw_ff;
      res_frame_in = res_frame_ff;
      res_chan_in  = res_chan_ff;
      res_pos_in   = res_pos_ff;
      res_count_in = res_count_ff;
      prev_we      = 1'b0;
      smooth_we    = 1'b0;
      div_start    = 1'b0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               width_in = req_pulse_width;
               jr_in    = req_inverted_polarity;
               if (req_pulse_width < RUNT_LIMIT) begin
                  state_in = ST_IDLE;
               end else if (req_pulse_width < sep_ff || skip_ff) begin
                  skip_in = 1'b0;
               end else if (req_pulse_width > sync_ff) begin
                  res_frame_in = 1'b1;
                  res_chan_in  = '0;
                  res_pos_in   = '0;
                  res_count_in = CHAN_BITS'(idx_ff);
                  synced_in    = 1'b1;
                  idx_in       = '0;
                  skip_in      = 1'b1;
                  state_in     = ST_DONE;
               end else if (synced_ff && idx_ff < CNT_BITS'(MAX_CHANNELS)) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            prev_we  = 1'b1;
            width_in = w_snap;
            if (max_ff <= min_ff || w_snap <= min_ff) begin
               raw_in   = jr_ff ? POS_MAX : '0;
               state_in = ST_SMOOTH;
            end else if ((w_snap - min_ff) >= span) begin
               raw_in   = jr_ff ? '0 : POS_MAX;
               state_in = ST_SMOOTH;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               if (!jr_ff) begin
                  raw_in = div_res.quot;
               end else if (jr_val[FRAC_BITS]) begin
                  raw_in = POS_MAX;
               end else begin
                  raw_in = jr_val[FRAC_BITS-1:0];
               end
               state_in = ST_SMOOTH;
            end
         end
         ST_SMOOTH: begin
            smooth_we    = 1'b1;
            res_frame_in = 1'b0;
            res_chan_in  = map_channel(idx, jr_ff);
            res_pos_in   = s_new;
            res_count_in = '0;
            if (idx_ff == CNT_BITS'(MAX_CHANNELS - 1)) begin
               synced_in = 1'b0;
            end
            idx_in   = idx_ff + CNT_BITS'(1);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         synced_ff    <= 1'b0;
         skip_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         sep_ff       <= SEPARATOR_RESET;
         sync_ff      <= SYNC_RESET;
         min_ff       <= MIN_RESET;
         max_ff       <= MAX_RESET;
      end else begin
         state_ff     <= state_in;
         synced_ff    <= synced_in;
         skip_ff      <= skip_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_SEPARATOR: sep_ff  <= csr_wdata;
               CSR_SYNC:      sync_ff <= csr_wdata;
               CSR_MIN:       min_ff  <= csr_wdata;
               CSR_MAX:       max_ff  <= csr_wdata;
               default:       sep_ff  <= sep_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            prev_ff[i]   <= '0;
            smooth_ff[i] <= '0;
         end
      end else begin
         if (prev_we) begin
            prev_ff[idx] <= w_snap;
         end
         if (smooth_we) begin
            smooth_ff[idx] <= s_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      width_ff     <= width_in;
      jr_ff        <= jr_in;
      raw_ff       <= raw_in;
      res_frame_ff <= res_frame_in;
      res_chan_ff  <= res_chan_in;
      res_pos_ff   <= res_pos_in;
      res_count_ff <= res_count_in;
      if (rsp_load) begin
         rsp_frame_ff <= res_frame_ff;
         rsp_chan_ff  <= res_chan_ff;
         rsp_pos_ff   <= res_pos_ff;
         rsp_count_ff <= res_count_ff;
      end
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_end     = rsp_frame_ff;
   assign rsp_channel       = rsp_chan_ff;
   assign rsp_position      = rsp_pos_ff;
   assign rsp_channel_count = rsp_count_ff;

   `PPMD_ASSERT_NOW(a_div_done_in_div, clock, reset, div_res.done, state_ff == ST_DIV)
   `PPMD_ASSERT_NOW(a_synced_index_range, clock, reset, synced_ff,
                    idx_ff < CNT_BITS'(MAX_CHANNELS))
   `PPMD_ASSERT_NEXT(a_done_loads_output, clock, reset,
                     state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready),
                     rsp_valid_ff && state_ff == ST_IDLE)
   `PPMD_ASSERT_NOW(a_frame_end_clean, clock, reset, rsp_valid_ff && rsp_frame_ff,
                    rsp_chan_ff == '0 && rsp_pos_ff == '0)

endmodule

`default_nettype wire
